// ----- rtl/core/slric_pkg.sv -----
// ----------------------------------------------------------------------------
// slric_pkg
// Shared types, codes and constant tables for the sidelink resource
// indication codec.
// ----------------------------------------------------------------------------
package slric_pkg;

  // Largest resource pool size the frequency encoder accepts
  localparam logic [4:0] MAX_SUBCH = 5'd27;

  localparam logic [4:0] NUM_SUBCH_RESET = 5'd10;

  // floor(x / 30) == (x * RECIP30) >> RECIP30_SHIFT for x below 1024
  localparam int unsigned RECIP30_SHIFT = 16;
  localparam logic [11:0] RECIP30       = 12'd2185;

  // Reservation counts
  localparam logic [1:0] NRES_NONE  = 2'd0;
  localparam logic [1:0] NRES_ONE   = 2'd1;
  localparam logic [1:0] NRES_TWO   = 2'd2;
  localparam logic [1:0] NRES_THREE = 2'd3;

  typedef enum logic [1:0] {
    MODE_TIME_ENC = 2'd0,
    MODE_FREQ_ENC = 2'd1,
    MODE_TIME_DEC = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_COUNT   = 2'd1,
    ERR_OPERAND = 2'd2
  } err_t;

  // Prefix sums of k (or k*k) for k = 1..m, indexed by m
  typedef logic [31:0][13:0] sum_tab_t;

  function automatic sum_tab_t build_sum_tab(input bit squares);
    sum_tab_t    tab;
    int unsigned acc;
    acc    = 0;
    tab[0] = '0;
    for (int unsigned i = 1; i < 32; i++) begin
      acc    = acc + (squares ? i * i : i);
      tab[i] = 14'(acc);
    end
    return tab;
  endfunction

  localparam sum_tab_t LIN_SUM = build_sum_tab(1'b0);
  localparam sum_tab_t SQ_SUM  = build_sum_tab(1'b1);

  // Stage 1 to stage 2
  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  nres;
    logic [4:0]  t1;
    logic [4:0]  gap;        // t2 - t1 - 1
    logic        t_bad;      // t2 <= t1
    logic        f_bad;
    logic [4:0]  s1;
    logic [13:0] sum_hi;
    logic [13:0] sum_lo;
    logic [10:0] s2_prod;
    logic [8:0]  tv;
    logic        r_ok;       // tv >= 31
    logic [8:0]  r;          // tv - 31
    logic [4:0]  qr;         // r / 30
    logic [9:0]  s;          // 962 - tv
    logic [5:0]  qs;         // s / 30
  } st1_t;

  // Stage 2 to output stage
  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  nres;
    logic        t_bad;
    logic [12:0] t_value;
    logic        f_bad;
    logic [12:0] f_value;
    logic [8:0]  tv;
    logic        a_ok;
    logic [4:0]  a_c;
    logic [4:0]  a_t2;
    logic        b_ok;
    logic [4:0]  b_c;
    logic [4:0]  b_t2;
  } st2_t;

endpackage

// ----- rtl/core/sidelink_resource_indication_codec.sv -----
// ----------------------------------------------------------------------------
// sidelink_resource_indication_codec
// Encodes sidelink time/frequency resource indication values and decodes a
// time value back into its two slot offsets. Three register stages: operand
// checks, table lookups and divide-by-30 reciprocal multiplies, then candidate
// arithmetic, then the result select into the output register. A transaction
// can enter every cycle; a stalled output holds the whole pipeline. Write
// num_subchannels only while idle.
// ----------------------------------------------------------------------------
module sidelink_resource_indication_codec (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_num_reserved,
  input  logic [4:0]  in_first_slot,
  input  logic [4:0]  in_second_slot,
  input  logic [8:0]  in_time_value_in,
  input  logic [4:0]  in_subch_length,
  input  logic [4:0]  in_first_start_subch,
  input  logic [4:0]  in_second_start_subch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] out_value_out,
  output logic [4:0]  out_first_slot_out,
  output logic [4:0]  out_second_slot_out,
  output logic [1:0]  out_error
);

  logic [4:0] num_subch_r;

  logic adv;
  logic v1_r, v2_r, out_valid_r;

  slric_pkg::st1_t st1_nxt, st1_r;
  slric_pkg::st2_t st2_nxt, st2_r;

  logic [12:0] value_nxt, value_r;
  logic [4:0]  slot1_nxt, slot1_r;
  logic [4:0]  slot2_nxt, slot2_r;
  logic [1:0]  err_nxt, err_r;

  // Whole pipeline moves when the output register is free or being drained
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_subch_r <= slric_pkg::NUM_SUBCH_RESET;
    end else if (cfg_we) begin
      num_subch_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st1_r   <= st1_nxt;
      st2_r   <= st2_nxt;
      value_r <= value_nxt;
      slot1_r <= slot1_nxt;
      slot2_r <= slot2_nxt;
      err_r   <= err_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: operand checks, prefix-sum lookups, reciprocal multiplies
  // --------------------------------------------------------------------------
  logic [4:0]  room;
  logic [5:0]  width_w;
  logic [20:0] mul_r;
  logic [21:0] mul_s;

  always_comb begin
    st1_nxt      = '0;
    st1_nxt.mode = in_mode;
    st1_nxt.nres = in_num_reserved;
    st1_nxt.t1   = in_first_slot;
    st1_nxt.gap  = in_second_slot - in_first_slot - 5'd1;
    st1_nxt.t_bad = (in_second_slot <= in_first_slot);

    room    = num_subch_r - in_subch_length;
    width_w = 6'(num_subch_r) + 6'd1 - 6'(in_subch_length);
    st1_nxt.f_bad = (num_subch_r == 5'd0) || (num_subch_r > slric_pkg::MAX_SUBCH) ||
                    (in_subch_length == 5'd0) || (in_subch_length > num_subch_r) ||
                    (in_first_start_subch > room) ||
                    ((in_num_reserved == slric_pkg::NRES_THREE) &&
                     (in_second_start_subch > room));
    st1_nxt.s1 = in_first_start_subch;
    if (in_num_reserved == slric_pkg::NRES_TWO) begin
      st1_nxt.sum_hi = slric_pkg::LIN_SUM[num_subch_r];
      st1_nxt.sum_lo = slric_pkg::LIN_SUM[width_w[4:0]];
      st1_nxt.s2_prod = '0;
    end else begin
      st1_nxt.sum_hi = slric_pkg::SQ_SUM[num_subch_r];
      st1_nxt.sum_lo = slric_pkg::SQ_SUM[width_w[4:0]];
      st1_nxt.s2_prod = 11'(in_second_start_subch) * 11'(width_w);
    end

    st1_nxt.tv   = in_time_value_in;
    st1_nxt.r_ok = (in_time_value_in >= 9'd31);
    st1_nxt.r    = in_time_value_in - 9'd31;
    st1_nxt.s    = 10'd962 - 10'(in_time_value_in);
    mul_r = 21'(st1_nxt.r) * 21'(slric_pkg::RECIP30);
    mul_s = 22'(st1_nxt.s) * 22'(slric_pkg::RECIP30);
    st1_nxt.qr = mul_r[slric_pkg::RECIP30_SHIFT +: 5];
    st1_nxt.qs = mul_s[slric_pkg::RECIP30_SHIFT +: 6];
  end

  // --------------------------------------------------------------------------
  // Stage 2: encoder values and best decode candidate of each gap branch
  // --------------------------------------------------------------------------
  logic [12:0] t_gap_v;
  logic [14:0] f_sum;
  logic [3:0]  a_d;
  logic [9:0]  a_c;
  logic [4:0]  b_d;
  logic [9:0]  b_c;

  always_comb begin
    st2_nxt      = '0;
    st2_nxt.mode = st1_r.mode;
    st2_nxt.nres = st1_r.nres;
    st2_nxt.tv   = st1_r.tv;

    // Short gap wraps forward from 31, long gap folds back from 62
    if (st1_r.gap <= 5'd15) begin
      t_gap_v = 13'(st1_r.gap) * 13'd30 + 13'(st1_r.t1) + 13'd31;
    end else begin
      t_gap_v = 13'(5'd30 - st1_r.gap) * 13'd30 + 13'd62 - 13'(st1_r.t1);
    end
    st2_nxt.t_bad = st1_r.t_bad;
    priority if (st1_r.nres == slric_pkg::NRES_ONE) begin
      st2_nxt.t_value = '0;
    end else if (st1_r.nres == slric_pkg::NRES_TWO) begin
      st2_nxt.t_value = 13'(st1_r.t1);
    end else begin
      st2_nxt.t_value = t_gap_v;
    end

    f_sum = 15'(st1_r.s1) + 15'(st1_r.s2_prod) + 15'(st1_r.sum_hi - st1_r.sum_lo);
    st2_nxt.f_bad   = st1_r.f_bad;
    st2_nxt.f_value = f_sum[12:0];

    // Largest gap gives the smallest first offset in each branch
    a_d          = (st1_r.qr > 5'd15) ? 4'd15 : st1_r.qr[3:0];
    a_c          = 10'(st1_r.r) - 10'(a_d) * 10'd30;
    st2_nxt.a_ok = st1_r.r_ok && ((a_c + 10'(a_d)) <= 10'd30);
    st2_nxt.a_c  = a_c[4:0];
    st2_nxt.a_t2 = a_c[4:0] + 5'(a_d) + 5'd1;

    b_d          = (st1_r.qs > 6'd30) ? 5'd30 : st1_r.qs[4:0];
    b_c          = st1_r.s - 10'(b_d) * 10'd30;
    st2_nxt.b_ok = (b_d >= 5'd16) && ((b_c + 10'(b_d)) <= 10'd30);
    st2_nxt.b_c  = b_c[4:0];
    st2_nxt.b_t2 = b_c[4:0] + b_d + 5'd1;
  end

  // --------------------------------------------------------------------------
  // Stage 3: pick the result by mode and error precedence
  // --------------------------------------------------------------------------
  logic pick_a;

  always_comb begin
    value_nxt = '0;
    slot1_nxt = '0;
    slot2_nxt = '0;
    err_nxt   = slric_pkg::ERR_NONE;
    // Same first offset in both branches: the short-gap fit is tried first
    pick_a    = st2_r.a_ok && (!st2_r.b_ok || (st2_r.a_c <= st2_r.b_c));

    priority if ((st2_r.nres == slric_pkg::NRES_NONE) ||
                 ((st2_r.mode == slric_pkg::MODE_FREQ_ENC) &&
                  (st2_r.nres < slric_pkg::NRES_TWO))) begin
      err_nxt = slric_pkg::ERR_COUNT;
    end else begin
      unique case (st2_r.mode)
        slric_pkg::MODE_TIME_ENC: begin
          if ((st2_r.nres == slric_pkg::NRES_THREE) && st2_r.t_bad) begin
            err_nxt = slric_pkg::ERR_OPERAND;
          end else begin
            value_nxt = st2_r.t_value;
          end
        end
        slric_pkg::MODE_FREQ_ENC: begin
          if (st2_r.f_bad) begin
            err_nxt = slric_pkg::ERR_OPERAND;
          end else begin
            value_nxt = st2_r.f_value;
          end
        end
        slric_pkg::MODE_TIME_DEC: begin
          priority if (st2_r.nres == slric_pkg::NRES_ONE) begin
            err_nxt = slric_pkg::ERR_NONE;
          end else if (st2_r.nres == slric_pkg::NRES_TWO) begin
            if (st2_r.tv > 9'd31) begin
              err_nxt = slric_pkg::ERR_OPERAND;
            end else begin
              slot1_nxt = st2_r.tv[4:0];
            end
          end else if (pick_a) begin
            slot1_nxt = st2_r.a_c;
            slot2_nxt = st2_r.a_t2;
          end else if (st2_r.b_ok) begin
            slot1_nxt = st2_r.b_c;
            slot2_nxt = st2_r.b_t2;
          end else begin
            err_nxt = slric_pkg::ERR_OPERAND;
          end
        end
        default: begin
          err_nxt = slric_pkg::ERR_OPERAND;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_value_out       = value_r;
  assign out_first_slot_out  = slot1_r;
  assign out_second_slot_out = slot2_r;
  assign out_error           = err_r;

`ifndef NO_ASSERTIONS
  a_err_clears_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_error != slric_pkg::ERR_NONE)) |->
      ((out_value_out == 13'd0) && (out_first_slot_out == 5'd0) &&
       (out_second_slot_out == 5'd0)))
    else $error("error result carries nonzero payload");

  a_decode_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_error == slric_pkg::ERR_NONE) && (out_second_slot_out != 5'd0)) |->
      ((out_second_slot_out > out_first_slot_out) && (out_value_out == 13'd0)))
    else $error("decoded slots out of order or mixed with encoded value");

  a_stage_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && adv) |=> out_valid)
    else $error("transaction lost between last stage and output register");
`endif

endmodule
